/* sv/kpq_pkg.sv */
`timescale 1ns / 1ps

package kpq_pkg;

    localparam int ENTRIES       = 256;
    localparam int PRIORITY_BITS = 16;

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int ID_W     = 8;
    localparam int AMOUNT_W = 16;
    localparam int STAMP_W  = 32;
    localparam int SUM_W    = ((PRIORITY_BITS > AMOUNT_W) ? PRIORITY_BITS : AMOUNT_W) + 1;
    localparam int CMP_W    = (IDX_W > ID_W) ? IDX_W : ID_W;

    typedef logic [PRIORITY_BITS-1:0] prio_t;
    typedef logic [STAMP_W-1:0]       stamp_t;
    typedef logic [IDX_W-1:0]         idx_t;

    localparam prio_t  PRIO_MAX  = {PRIORITY_BITS{1'b1}};
    localparam stamp_t STAMP_MAX = {STAMP_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_INCREASE = 2'd1,
        REQ_REMOVE   = 2'd2,
        REQ_QUERY    = 2'd3
    } req_t;

    // write broadcast to every cell
    typedef struct packed {
        logic                en;
        req_t                req;
        logic [ID_W-1:0]     id;
        logic [AMOUNT_W-1:0] amount;
        stamp_t              stamp;
    } wr_t;

    // best candidate handed along the chain during a scan
    typedef struct packed {
        logic   valid;
        prio_t  prio;
        stamp_t stamp;
        idx_t   id;
    } cand_t;

    // saturating add; with p = 0 it clamps an insert value
    function automatic prio_t sat_add(prio_t p, logic [AMOUNT_W-1:0] a);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(a);
        if (s > SUM_W'(PRIO_MAX))
        begin
            return PRIO_MAX;
        end
        return PRIORITY_BITS'(s);
    endfunction

endpackage

/* sv/kpq_cell.sv */
`timescale 1ns / 1ps

module kpq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  kpq_pkg::idx_t   cell_index,
    input  kpq_pkg::wr_t    wr,
    input  logic            go_in,
    input  kpq_pkg::cand_t  cand_in,
    output logic            go_out,
    output kpq_pkg::cand_t  cand_out
);

    kpq_pkg::prio_t  prio_reg,  prio_next;
    kpq_pkg::stamp_t stamp_reg, stamp_next;
    logic            valid_reg, valid_next;
    logic            go_reg;
    kpq_pkg::cand_t  cand_reg,  cand_next;
    logic            hit;
    logic            wins;

    assign hit = wr.en &&
        (kpq_pkg::CMP_W'(cell_index) == kpq_pkg::CMP_W'(wr.id));

    always_comb
    begin
        prio_next  = prio_reg;
        stamp_next = stamp_reg;
        valid_next = valid_reg;
        if (hit)
        begin
            case (wr.req)
                kpq_pkg::REQ_INSERT:
                begin
                    prio_next  = kpq_pkg::sat_add('0, wr.amount);
                    stamp_next = wr.stamp;
                    valid_next = 1'b1;
                end
                kpq_pkg::REQ_INCREASE:
                begin
                    prio_next = kpq_pkg::sat_add(prio_reg, wr.amount);
                end
                kpq_pkg::REQ_REMOVE:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // own entry wins on priority, then earlier stamp; a full tie keeps lower id
    assign wins = valid_reg &&
        (!cand_in.valid || (prio_reg > cand_in.prio) ||
         ((prio_reg == cand_in.prio) && (stamp_reg < cand_in.stamp)));

    always_comb
    begin
        cand_next = cand_in;
        if (wins)
        begin
            cand_next.valid = 1'b1;
            cand_next.prio  = prio_reg;
            cand_next.stamp = stamp_reg;
            cand_next.id    = cell_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg  <= '0;
            stamp_reg <= '0;
            valid_reg <= 1'b0;
            go_reg    <= 1'b0;
        end
        else
        begin
            prio_reg  <= prio_next;
            stamp_reg <= stamp_next;
            valid_reg <= valid_next;
            go_reg    <= go_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_in)
        begin
            cand_reg <= cand_next;
        end
    end

    assign go_out   = go_reg;
    assign cand_out = cand_reg;

endmodule

/* sv/keyed_priority_queue_update_remove_top.sv */
`timescale 1ns / 1ps

// Keyed priority table: insert, increase, remove and query by entry id.
// Input channel: in_valid / in_stall, beat = {req_type, entry_id, amount}.
// Output channel: out_valid / out_stall, beat = {found, top_id}; only a
// query yields an output beat.
// Insert, increase and remove are registered in the addressed cell and
// back-to-back beats are taken. A query walks a chain of ENTRIES cells,
// one cell per cycle, each keeping the better of its own entry and the
// candidate handed in. in_stall goes high once the query beat is taken
// and stays high until the result has moved into the output register.
// If the receiver stalls when the scan ends, the result waits in a holding
// register and in_stall stays high until the output register takes it.
// A stalled output beat holds its value; no input beat of any kind is
// taken while a finished result waits in the holding register.
// Reset (rst_n low, asynchronous) empties the table, zeroes priorities and
// stamps, clears the arrival counter and drops any pending output.
// Ties: equal priority goes to the earlier arrival, then to the lower id.
module keyed_priority_queue_update_remove_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  entry_id,
    input  logic [15:0] amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [7:0]  top_id
);

    localparam int N = kpq_pkg::ENTRIES;

    logic            busy_reg,     busy_next;
    kpq_pkg::stamp_t counter_reg,  counter_next;
    logic            out_valid_reg, out_valid_next;
    logic            found_reg,    found_next;
    logic [7:0]      top_id_reg,   top_id_next;
    logic            pend_reg,     pend_next;
    logic            pend_found_reg, pend_found_next;
    logic [7:0]      pend_id_reg,  pend_id_next;

    logic            in_accept;
    logic            in_range;
    logic            out_free;
    logic            scan_done;
    logic            load_out;
    kpq_pkg::req_t   req;
    kpq_pkg::wr_t    wr;

    logic            go   [N+1];
    kpq_pkg::cand_t  cand [N+1];

    assign req       = kpq_pkg::req_t'(req_type);
    assign in_accept = in_valid && !busy_reg;
    assign in_range  = (int'(entry_id) < N);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        wr.en     = in_accept && in_range && (req != kpq_pkg::REQ_QUERY);
        wr.req    = req;
        wr.id     = entry_id;
        wr.amount = amount;
        wr.stamp  = counter_reg;
    end

    assign go[0]   = in_accept && (req == kpq_pkg::REQ_QUERY);
    assign cand[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        kpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (kpq_pkg::IDX_W'(i)),
            .wr         (wr),
            .go_in      (go[i]),
            .cand_in    (cand[i]),
            .go_out     (go[i+1]),
            .cand_out   (cand[i+1])
        );
    end

    assign scan_done = go[N];

    // arrival stamps, saturating
    always_comb
    begin
        counter_next = counter_reg;
        if (wr.en && (req == kpq_pkg::REQ_INSERT) && (counter_reg != kpq_pkg::STAMP_MAX))
        begin
            counter_next = counter_reg + 1'b1;
        end
    end

    // result path: chain end -> output register, or via holding register
    always_comb
    begin
        load_out        = 1'b0;
        found_next      = found_reg;
        top_id_next     = top_id_reg;
        pend_next       = pend_reg;
        pend_found_next = pend_found_reg;
        pend_id_next    = pend_id_reg;
        if (scan_done)
        begin
            if (out_free)
            begin
                load_out    = 1'b1;
                found_next  = cand[N].valid;
                top_id_next = cand[N].valid ? 8'(cand[N].id) : 8'd0;
            end
            else
            begin
                pend_next       = 1'b1;
                pend_found_next = cand[N].valid;
                pend_id_next    = cand[N].valid ? 8'(cand[N].id) : 8'd0;
            end
        end
        else if (pend_reg && out_free)
        begin
            load_out    = 1'b1;
            pend_next   = 1'b0;
            found_next  = pend_found_reg;
            top_id_next = pend_id_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (go[0])
        begin
            busy_next = 1'b1;
        end
        else if (load_out)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg      <= found_next;
        top_id_reg     <= top_id_next;
        pend_found_reg <= pend_found_next;
        pend_id_reg    <= pend_id_next;
    end

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign top_id    = top_id_reg;

endmodule

/* sv/kpq_checker.sv */
`timescale 1ns / 1ps

module kpq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [7:0]  top_id
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(top_id))
        else $error("output beat changed under stall");

    // empty table reports id zero
    a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> top_id == 8'd0)
        else $error("empty result with non-zero id");

    // an accepted query blocks the input while the scan runs
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == kpq_pkg::REQ_QUERY) |=> in_stall)
        else $error("input not stalled after query");

    // a fresh result only appears at the end of a scan
    a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output beat without a running query");

    // non-query beats never start a scan
    a_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !(in_valid && (req_type == kpq_pkg::REQ_QUERY)) |=> !in_stall)
        else $error("input stalled without a query");

endmodule

bind keyed_priority_queue_update_remove_top kpq_checker u_kpq_checker (.*);
